[rtl/task_slot_table_top_defines.svh]
// assertion macros used by the task slot table engine (tst_back)
// no dependencies; included by tst_back, the only module that carries assertions
`ifndef TASK_SLOT_TABLE_TOP_DEFINES_SVH
`define TASK_SLOT_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task slot table: same-cycle check failed");

// next-cycle implication, disabled in reset
`define TST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task slot table: next-cycle check failed");

`endif

[rtl/tst_pkg.sv]
// types, constants and helpers of the task slot table
// no dependencies; imported by every task slot table module
`timescale 1ns / 1ps

package tst_pkg;

    localparam int SLOT_COUNT       = 64;
    localparam int FIXED_SLOT_COUNT = 32;
    localparam int SLOT_W           = $clog2(SLOT_COUNT);
    localparam int POOL_COUNT       = (SLOT_COUNT > FIXED_SLOT_COUNT) ?
                                      (SLOT_COUNT - FIXED_SLOT_COUNT) : 1;
    localparam int GRP_SIZE         = 8;
    localparam int GRP_W            = $clog2(GRP_SIZE);
    localparam int GRP_COUNT        = (POOL_COUNT + GRP_SIZE - 1) / GRP_SIZE;

    localparam int OP_W       = 2;
    localparam int ORIGIN_W   = 2;
    localparam int KIND_W     = 2;
    localparam int TGT_W      = 15;
    localparam int CNT_W      = 16;
    localparam int SLOT_ID_W  = 6;
    localparam int STATUS_W   = 3;
    localparam int REM_W      = 17;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_COME     = 2'd1,
        OP_LAST     = 2'd2,
        OP_OVER     = 2'd3
    } t_op;

    typedef enum logic [ORIGIN_W-1:0] {
        ORIGIN_FIXED = 2'd0,
        ORIGIN_POOL  = 2'd1
    } t_origin;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALONE = 2'd0,
        KIND_WHOLE = 2'd1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_BAD_ORIGIN = 3'd2,
        ST_BAD_KIND   = 3'd3,
        ST_BUSY       = 3'd4,
        ST_UNUSED     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CMD_FAIL      = 3'd0,
        CMD_REG_FIXED = 3'd1,
        CMD_REG_POOL  = 3'd2,
        CMD_COME      = 3'd3,
        CMD_LAST      = 3'd4,
        CMD_OVER      = 3'd5
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [CNT_W-1:0] worker_target;
        logic [CNT_W-1:0] tasker_target;
        logic [CNT_W-1:0] worker_done;
        logic [CNT_W-1:0] tasker_done;
    } t_entry;

    typedef struct packed {
        t_cmd                 cmd;
        t_status              fail_status;
        logic                 kind_bad;
        logic [SLOT_W-1:0]    idx;
        logic [SLOT_ID_W-1:0] slot_out;
        logic [CNT_W-1:0]     worker_target;
        logic [CNT_W-1:0]     tasker_target;
        logic [CNT_W-1:0]     check_count;
    } t_qitem;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

[rtl/tst_front.sv]
// front end: takes input words and turns them into queue commands
// depends on tst_pkg
`timescale 1ns / 1ps

module tst_front (
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tst_pkg::OP_W-1:0]        i_op,
    input  logic [tst_pkg::ORIGIN_W-1:0]    i_origin_kind,
    input  logic [tst_pkg::KIND_W-1:0]      i_task_kind,
    input  logic [tst_pkg::TGT_W-1:0]       i_worker_count,
    input  logic [tst_pkg::TGT_W-1:0]       i_tasker_count,
    input  logic [tst_pkg::SLOT_ID_W-1:0]   i_slot,
    input  logic [tst_pkg::CNT_W-1:0]       i_check_count,
    input  logic                            i_push_ready,
    output logic                            o_push,
    output tst_pkg::t_qitem                 o_item
);
    import tst_pkg::*;

    logic in_range;
    logic whole;

    assign o_in_ready = i_push_ready;
    assign o_push     = i_in_valid && i_push_ready;
    assign in_range   = 32'(i_slot) < SLOT_COUNT;
    assign whole      = (i_task_kind == KIND_WHOLE);

    always_comb begin
        o_item               = '0;
        o_item.cmd           = CMD_FAIL;
        o_item.fail_status   = ST_OK;
        o_item.idx           = SLOT_W'(i_slot);
        o_item.slot_out      = i_slot;
        o_item.check_count   = i_check_count;
        o_item.kind_bad      = !(i_task_kind == KIND_ALONE || i_task_kind == KIND_WHOLE);
        // alone sets both targets to one
        o_item.worker_target = whole ? CNT_W'(i_worker_count) : CNT_W'(1);
        o_item.tasker_target = whole ? CNT_W'(i_tasker_count) : CNT_W'(1);
        unique case (t_op'(i_op))
            OP_REGISTER: begin
                if (i_origin_kind == ORIGIN_FIXED && in_range) begin
                    o_item.cmd = CMD_REG_FIXED;
                end else if (i_origin_kind == ORIGIN_POOL) begin
                    o_item.cmd = CMD_REG_POOL;
                end else begin
                    o_item.fail_status = ST_BAD_ORIGIN;
                    o_item.slot_out    = '0;
                end
            end
            OP_COME: begin
                if (in_range) o_item.cmd = CMD_COME;
                else          o_item.fail_status = ST_UNUSED;
            end
            OP_LAST: begin
                if (in_range) o_item.cmd = CMD_LAST;
                else          o_item.fail_status = ST_UNUSED;
            end
            OP_OVER: begin
                if (in_range) o_item.cmd = CMD_OVER;
                else          o_item.fail_status = ST_UNUSED;
            end
        endcase
    end

endmodule

[rtl/tst_queue.sv]
// short command queue between front end and table engine
// depends on tst_pkg
`timescale 1ns / 1ps

module tst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tst_pkg::t_qitem i_item,
    output logic            o_push_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output tst_pkg::t_qitem o_item
);
    import tst_pkg::*;

    t_qitem              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_item       = r_slots[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_slots[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_next(r_rd_ptr);
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

[rtl/tst_back.sv]
// table engine: slot memory, busy flags, free-slot search and result register
// depends on tst_pkg and task_slot_table_top_defines.svh
`timescale 1ns / 1ps
`include "task_slot_table_top_defines.svh"

module tst_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_item_valid,
    input  tst_pkg::t_qitem                 i_item,
    output logic                            o_item_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tst_pkg::STATUS_W-1:0]    o_status,
    output logic [tst_pkg::SLOT_ID_W-1:0]   o_slot_id,
    output logic [tst_pkg::CNT_W-1:0]       o_finish_count,
    output logic                            o_is_last,
    output logic signed [tst_pkg::REM_W-1:0] o_remaining,
    output logic                            o_released
);
    import tst_pkg::*;

    t_back_state            r_state, n_state;
    t_qitem                 r_cur;
    t_entry                 r_mem [SLOT_COUNT];
    t_entry                 r_rd_data;
    logic                   r_rd_ok;
    logic [SLOT_COUNT-1:0]  r_busy;
    logic [SLOT_COUNT-1:0]  r_valid;
    logic                   r_grp_any [GRP_COUNT];
    logic [GRP_W-1:0]       r_grp_idx [GRP_COUNT];
    logic                   n_grp_any [GRP_COUNT];
    logic [GRP_W-1:0]       n_grp_idx [GRP_COUNT];

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [SLOT_ID_W-1:0]   r_out_slot;
    logic [CNT_W-1:0]       r_out_finish;
    logic                   r_out_last;
    logic signed [REM_W-1:0] r_out_rem;
    logic                   r_out_rel;

    logic                   exec_fire;
    t_entry                 entry;
    logic                   busy_cur;
    logic                   pool_found;
    logic [SLOT_W-1:0]      pool_id;

    t_status                res_status;
    logic [SLOT_ID_W-1:0]   res_slot;
    logic [CNT_W-1:0]       res_finish;
    logic                   res_last;
    logic signed [REM_W-1:0] res_rem;
    logic                   res_rel;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    t_entry                 wr_data;
    logic                   wr_valid;
    logic                   wr_busy;

    // sequencer: read the slot, then modify and write it back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        exec_fire  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    exec_fire = 1'b1;
                    n_state   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_cur     <= i_item;
            r_rd_data <= r_mem[i_item.idx];
            r_rd_ok   <= r_valid[i_item.idx];
        end
    end

    // an entry never written since reset or release reads as zero
    assign entry    = r_rd_ok ? r_rd_data : '0;
    assign busy_cur = r_busy[r_cur.idx];

    // per-group free summary of the pooled region, refreshed every cycle
    always_comb begin
        for (int g = 0; g < GRP_COUNT; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_idx[g] = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--) begin
                if (FIXED_SLOT_COUNT + g * GRP_SIZE + j < SLOT_COUNT) begin
                    if (!r_busy[SLOT_W'(FIXED_SLOT_COUNT + g * GRP_SIZE + j)]) begin
                        n_grp_any[g] = 1'b1;
                        n_grp_idx[g] = GRP_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= n_grp_any;
        r_grp_idx <= n_grp_idx;
    end

    // lowest group with a free slot wins
    always_comb begin
        pool_found = 1'b0;
        pool_id    = '0;
        for (int g = GRP_COUNT - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                pool_found = 1'b1;
                pool_id    = SLOT_W'(FIXED_SLOT_COUNT + g * GRP_SIZE + int'(r_grp_idx[g]));
            end
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_slot   = r_cur.slot_out;
        res_finish = '0;
        res_last   = 1'b0;
        res_rem    = '0;
        res_rel    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_cur.idx;
        wr_data    = entry;
        wr_valid   = 1'b1;
        wr_busy    = busy_cur;
        unique case (r_cur.cmd)
            CMD_FAIL: begin
                res_status = r_cur.fail_status;
            end
            CMD_REG_FIXED: begin
                if (busy_cur) begin
                    res_status = ST_BUSY;
                    res_slot   = '0;
                end else if (r_cur.kind_bad) begin
                    res_status = ST_BAD_KIND;
                    res_slot   = '0;
                end else begin
                    wr_en   = 1'b1;
                    wr_busy = 1'b1;
                    wr_data = '{r_cur.worker_target, r_cur.tasker_target, '0, '0};
                end
            end
            CMD_REG_POOL: begin
                if (!pool_found) begin
                    res_status = ST_NO_FREE;
                    res_slot   = '0;
                end else if (r_cur.kind_bad) begin
                    res_status = ST_BAD_KIND;
                    res_slot   = '0;
                end else begin
                    wr_en    = 1'b1;
                    wr_busy  = 1'b1;
                    wr_addr  = pool_id;
                    wr_data  = '{r_cur.worker_target, r_cur.tasker_target, '0, '0};
                    res_slot = SLOT_ID_W'(pool_id);
                end
            end
            CMD_COME: begin
                wr_en               = 1'b1;
                wr_data.tasker_done = sat_inc(entry.tasker_done);
                res_finish          = sat_inc(entry.tasker_done);
            end
            CMD_LAST: begin
                res_last = (r_cur.check_count == entry.tasker_target);
            end
            CMD_OVER: begin
                if (!busy_cur) begin
                    res_status = ST_UNUSED;
                end else if (entry.worker_target != '0 &&
                             entry.worker_done == entry.worker_target - CNT_W'(1)) begin
                    // last expected worker: free the slot and clear its valid bit so it reads as zero
                    wr_en    = 1'b1;
                    wr_valid = 1'b0;
                    wr_busy  = 1'b0;
                    res_rel  = 1'b1;
                end else begin
                    wr_en               = 1'b1;
                    wr_data.worker_done = sat_inc(entry.worker_done);
                    res_rem = $signed({1'b0, entry.worker_target}) -
                              $signed({1'b0, entry.worker_done});
                end
            end
            default: begin
                res_status = ST_UNUSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire && wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_valid <= '0;
        end else if (exec_fire && wr_en) begin
            r_busy[wr_addr]  <= wr_busy;
            r_valid[wr_addr] <= wr_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_out_valid <= 1'b0;
        else if (exec_fire)   r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot;
            r_out_finish <= res_finish;
            r_out_last   <= res_last;
            r_out_rem    <= res_rem;
            r_out_rel    <= res_rel;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_id      = r_out_slot;
    assign o_finish_count = r_out_finish;
    assign o_is_last      = r_out_last;
    assign o_remaining    = r_out_rem;
    assign o_released     = r_out_rel;

    `TST_ASSERT_NEXT(a_pop_then_exec, i_clk, i_rst_n, o_item_pop, r_state == S_EXEC)
    `TST_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_state == S_EXEC && r_out_valid && !i_out_ready, r_state == S_EXEC)
    `TST_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, exec_fire, r_out_valid)
    `TST_ASSERT_IMPL(a_fail_no_write, i_clk, i_rst_n, exec_fire && res_status != ST_OK, !wr_en)
    `TST_ASSERT_IMPL(a_release_on_over, i_clk, i_rst_n, exec_fire && res_rel, r_cur.cmd == CMD_OVER && res_status == ST_OK)

endmodule

[rtl/task_slot_table_top.sv]
// task slot table top level: front end, command queue and table engine
// depends on tst_pkg, tst_front, tst_queue and tst_back
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_ready) carries one request word: op, origin
// and task kind, targets, slot and check count. Output channel (o_out_valid /
// i_out_ready) returns exactly one result word per request, in order.
// With the block otherwise empty, an accepted request word is written into the
// queue, popped into the engine's current-item register, then executed into the
// result register, where its result word goes valid. The engine takes a new word
// only once the last one is through the read then modify-write of one slot entry
// via the slot memory's single read and write port and into the result register.
// A two-entry queue sits between the front end and the table engine, so the
// front keeps taking words while a result waits in the output register; once
// the queue fills, o_in_ready drops until the receiver takes the result.
// Reset: synchronous, active low. Every slot is free with all targets and
// counters zero right after reset; per-slot valid bits make that immediate,
// so there is no clearing pass. Output valid is low after reset.

module task_slot_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tst_pkg::OP_W-1:0]         i_op,
    input  logic [tst_pkg::ORIGIN_W-1:0]     i_origin_kind,
    input  logic [tst_pkg::KIND_W-1:0]       i_task_kind,
    input  logic [tst_pkg::TGT_W-1:0]        i_worker_count,
    input  logic [tst_pkg::TGT_W-1:0]        i_tasker_count,
    input  logic [tst_pkg::SLOT_ID_W-1:0]    i_slot,
    input  logic [tst_pkg::CNT_W-1:0]        i_check_count,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tst_pkg::STATUS_W-1:0]     o_status,
    output logic [tst_pkg::SLOT_ID_W-1:0]    o_slot_id,
    output logic [tst_pkg::CNT_W-1:0]        o_finish_count,
    output logic                             o_is_last,
    output logic signed [tst_pkg::REM_W-1:0] o_remaining,
    output logic                             o_released
);
    import tst_pkg::*;

    logic   push;
    logic   push_ready;
    t_qitem push_item;
    logic   q_valid;
    logic   q_pop;
    t_qitem q_item;

    tst_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_origin_kind  (i_origin_kind),
        .i_task_kind    (i_task_kind),
        .i_worker_count (i_worker_count),
        .i_tasker_count (i_tasker_count),
        .i_slot         (i_slot),
        .i_check_count  (i_check_count),
        .i_push_ready   (push_ready),
        .o_push         (push),
        .o_item         (push_item)
    );

    tst_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_item       (q_item)
    );

    tst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .i_item         (q_item),
        .o_item_pop     (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_slot_id      (o_slot_id),
        .o_finish_count (o_finish_count),
        .o_is_last      (o_is_last),
        .o_remaining    (o_remaining),
        .o_released     (o_released)
    );

endmodule
